@@ rtl/salc_pkg.sv @@
package salc_pkg;

  // Default geometry of the tag store
  localparam int DEF_NUM_SETS   = 128;
  localparam int DEF_NUM_WAYS   = 8;
  localparam int DEF_LINE_BYTES = 32;
  localparam int DEF_ADDR_WIDTH = 32;

  // Fixed payload widths of the request and result channels
  localparam int REQ_ADDR_W  = 32;
  localparam int RSP_WAY_W   = 3;
  localparam int RSP_ADDR_W  = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_wr;   // write the reset image into the row at the sweep index
    logic lookup_rd;  // capture the request and read its set row
    logic commit;     // write the updated row and load the result register
  } salc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last; // the sweep index points at the last row
  } salc_status_t;

endpackage

@@ rtl/salc_if.sv @@
interface salc_req_if import salc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [REQ_ADDR_W-1:0] address;

  modport source (output valid, output action, output address, input ready);
  modport sink   (input valid, input action, input address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [RSP_WAY_W-1:0]  way_used;
  logic                  evicted;
  logic                  needs_writeback;
  logic [RSP_ADDR_W-1:0] victim_line_address;

  modport source (output valid, output hit, output way_used, output evicted,
                  output needs_writeback, output victim_line_address, input ready);
  modport sink   (input valid, input hit, input way_used, input evicted,
                  input needs_writeback, input victim_line_address, output ready);
endinterface

@@ rtl/salc_ram.sv @@
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/salc_ctrl.sv @@
module salc_ctrl import salc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output salc_cmd_t    cmd,
  input  salc_status_t st
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Sequence clear sweep, request read and row update
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.lookup_rd = 1'b1;
          state_nxt     = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold the lookup while the result register is still full
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/salc_dp.sv @@
module salc_dp import salc_pkg::*; #(
  parameter int NUM_SETS   = DEF_NUM_SETS,
  parameter int NUM_WAYS   = DEF_NUM_WAYS,
  parameter int LINE_BYTES = DEF_LINE_BYTES,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  salc_cmd_t             cmd,
  output salc_status_t          st,
  input  logic                  in_action,
  input  logic [REQ_ADDR_W-1:0] in_address,
  output logic                  out_hit,
  output logic [RSP_WAY_W-1:0]  out_way_used,
  output logic                  out_evicted,
  output logic                  out_needs_writeback,
  output logic [RSP_ADDR_W-1:0] out_victim_line_address
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int SETB   = $clog2(NUM_SETS);
  localparam int SET_W  = (SETB > 0) ? SETB : 1;
  localparam int EA_W   = (ADDR_WIDTH < REQ_ADDR_W) ? ADDR_WIDTH : REQ_ADDR_W;
  localparam int TAG_R  = EA_W - OFF_W - SETB;
  localparam int TAG_W  = (TAG_R > 0) ? TAG_R : 1;
  localparam int AGE_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WAY_W  = AGE_W;
  localparam int ENT_W  = TAG_W + 2 + AGE_W;
  localparam int ROW_W  = NUM_WAYS * ENT_W;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'((64'(1) << SETB) - 64'(1));
  localparam logic [AGE_W-1:0] AGE_LRU  = AGE_W'(NUM_WAYS - 1);

  // Split the narrowed address into set and tag
  logic [EA_W-1:0]  addr_eff;
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  assign addr_eff = in_address[EA_W-1:0];
  assign set_in   = SET_W'(addr_eff >> OFF_W) & SET_MASK;
  assign tag_in   = TAG_W'(addr_eff >> (OFF_W + SETB));

  // Capture the request
  logic             req_write_r;
  logic [SET_W-1:0] req_set_r;
  logic [TAG_W-1:0] req_tag_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup_rd) begin
      req_write_r <= in_action;
      req_set_r   <= set_in;
      req_tag_r   <= tag_in;
    end
  end

  // Advance the clear sweep index
  logic [SET_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx_r <= (clr_idx_r == SET_W'(NUM_SETS - 1)) ? '0 : clr_idx_r + SET_W'(1);
    end
  end

  assign st.clear_last = (clr_idx_r == SET_W'(NUM_SETS - 1));

  // Row store: one row per set, entry = {tag, valid, dirty, age}
  logic [ROW_W-1:0] rd_row, new_row, init_row, wr_row;
  logic [SET_W-1:0] wr_addr;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      init_row[w*ENT_W +: ENT_W] = {TAG_W'(0), 1'b0, 1'b0, AGE_W'(w)};
    end
  end

  assign wr_row  = cmd.clear_wr ? init_row : new_row;
  assign wr_addr = cmd.clear_wr ? clr_idx_r : req_set_r;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (cmd.clear_wr | cmd.commit),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (cmd.lookup_rd),
    .rd_addr (set_in),
    .rd_data (rd_row)
  );

  // Unpack the set row
  logic [TAG_W-1:0] e_tag   [NUM_WAYS];
  logic             e_valid [NUM_WAYS];
  logic             e_dirty [NUM_WAYS];
  logic [AGE_W-1:0] e_age   [NUM_WAYS];

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      {e_tag[w], e_valid[w], e_dirty[w], e_age[w]} = rd_row[w*ENT_W +: ENT_W];
    end
  end

  // Compare tags and pick the way: hit, else lowest invalid, else LRU
  logic             any_hit, any_inval;
  logic [WAY_W-1:0] hit_way, inval_way, lru_way, sel_way;
  logic             evict;
  logic [AGE_W-1:0] old_age;

  always_comb begin
    any_hit   = 1'b0;
    any_inval = 1'b0;
    hit_way   = '0;
    inval_way = '0;
    lru_way   = '0;
    // scan downward so the lowest matching way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (e_valid[w] && e_tag[w] == req_tag_r) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!e_valid[w]) begin
        any_inval = 1'b1;
        inval_way = WAY_W'(w);
      end
      if (e_age[w] == AGE_LRU) begin
        lru_way = WAY_W'(w);
      end
    end
  end

  assign sel_way = any_hit ? hit_way : (any_inval ? inval_way : lru_way);
  assign evict   = ~any_hit & ~any_inval;
  assign old_age = e_age[sel_way];

  // Build the updated row: touched way becomes most recent
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == sel_way) begin
        new_row[w*ENT_W +: ENT_W] = {
          any_hit ? e_tag[w] : req_tag_r,
          1'b1,
          any_hit ? (e_dirty[w] | req_write_r) : req_write_r,
          AGE_W'(0)
        };
      end else begin
        new_row[w*ENT_W +: ENT_W] = {
          e_tag[w], e_valid[w], e_dirty[w],
          (e_age[w] < old_age) ? e_age[w] + AGE_W'(1) : e_age[w]
        };
      end
    end
  end

  // Rebuild the victim line address
  logic [63:0] victim_full;

  assign victim_full = (64'(e_tag[sel_way]) << (SETB + OFF_W)) | (64'(req_set_r) << OFF_W);

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit                 <= any_hit;
      out_way_used            <= RSP_WAY_W'(sel_way);
      out_evicted             <= evict;
      out_needs_writeback     <= evict & e_dirty[sel_way];
      out_victim_line_address <= evict ? victim_full[RSP_ADDR_W-1:0] : '0;
    end
  end

endmodule

@@ rtl/set_assoc_lru_cache_tags_top.sv @@
// Tag and true-LRU controller of a write-back, write-allocate, set-associative
// cache. Each request (read/write flag and byte address) looks up its set, and
// one result reports hit, the way hit or filled, and, when a valid line is
// replaced, whether it was dirty and its line-aligned address. NUM_SETS and
// LINE_BYTES must be powers of two. A request first reads the set's row from the
// registered-read tag RAM, then updates the row and writes it back; in_req.ready
// is high only between requests. The result sits in an output register, so a
// request is taken while the previous result waits; a request finishing while
// that result is still unread holds until it is taken. After reset the block
// sweeps every row of the tag RAM, with in_req.ready low, to clear valid and
// dirty bits and seed the LRU order.
module set_assoc_lru_cache_tags_top import salc_pkg::*; #(
  parameter int NUM_SETS   = DEF_NUM_SETS,
  parameter int NUM_WAYS   = DEF_NUM_WAYS,
  parameter int LINE_BYTES = DEF_LINE_BYTES,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input logic        clk,
  input logic        rst_n,
  salc_req_if.sink   in_req,
  salc_rsp_if.source out_rsp
);

  salc_cmd_t    cmd;
  salc_status_t st;

  // Sequence the requests
  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .st        (st)
  );

  // Tag store, lookup and result register
  salc_dp #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .st                      (st),
    .in_action               (in_req.action),
    .in_address              (in_req.address),
    .out_hit                 (out_rsp.hit),
    .out_way_used            (out_rsp.way_used),
    .out_evicted             (out_rsp.evicted),
    .out_needs_writeback     (out_rsp.needs_writeback),
    .out_victim_line_address (out_rsp.victim_line_address)
  );

endmodule
